[rtl/hsf_pkg.sv]
// Shared types and constants for the FTCS heat stencil step unit.
// Used by every module of the block; depends on nothing else.
package hsf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 15;
   localparam int GRID_REG_W = 8;
   localparam int LAP_W      = 19;
   localparam int MUL_W      = 35;
   localparam int RND_W      = MUL_W + 1;
   localparam int FRAC_SHIFT = 16;
   localparam int DELTA_W    = RND_W - FRAC_SHIFT;
   localparam int SUM_W      = DELTA_W + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COEF_W;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COEF   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_POINTS = 1'b1;

   localparam logic [COEF_W-1:0]     COEF_RESET = 15'd13107;
   localparam logic [GRID_REG_W-1:0] GRID_RESET = 8'd101;
   localparam int                    GRID_MIN   = 3;

   localparam logic [SAMPLE_W-1:0] ONE_Q15    = 16'h8000;
   localparam logic [RND_W-1:0]    ROUND_HALF = 36'd32768;

   localparam int OQ_DEPTH = 2;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_start;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                is_last;
   } rsp_type;

   // One column slot of the two line buffers.
   typedef struct packed {
      logic [SAMPLE_W-1:0] newer;
      logic [SAMPLE_W-1:0] older;
   } line_pair_type;

   typedef struct packed {
      logic signed [LAP_W-1:0] lap;
      logic [SAMPLE_W-1:0]     centre;
      logic                    emit;
      logic                    dual;
      logic                    border;
      logic                    last;
   } stage_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] centre;
      logic                emit;
      logic                dual;
      logic                border;
      logic                last;
   } ctl_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                has_second;
      logic                last;
   } oq_entry_type;

   typedef struct packed {
      logic [OQ_CNT_W-1:0] count;
      logic                phase;
   } oq_status_type;

endpackage

[rtl/heat_stencil_ftcs_step_unit.sv]
// Top level of the FTCS five-point heat stencil step unit.
// Instantiates hsf_cell, hsf_update and hsf_outq; uses hsf_pkg.
//
// Usage: old-step samples enter on req_* in raster order, frame_start set on
// the first sample of a grid. Each sample of row r gives the new value of
// row r-1 at the same column on rsp_*; row 0 gives nothing, and each sample
// of the last row gives two results: the row above, then the zero border
// value of the last row (is_last set on the very final one).
// Throughput: one sample per clock while the result queue has space; in the
// last row each sample gives two results on the single result port, which
// holds the input back. A result is registered in the front stage, then in
// the multiplier; round/saturate feed the two-entry result queue directly.
// The line buffers are a row of GRID_MAX shifting cells whose entry point
// follows grid_points, so no memory port limits the rate.
// csr_* writes step_coefficient (index 0) or grid_points (index 1); write
// only while no results are pending. Reset restores coefficient 13107 and
// grid size 101, clears the position and empties the queue.
// When rsp_ready stays low the queue fills and req_ready drops; the whole
// pipeline holds its contents until the queue drains.
module heat_stencil_ftcs_step_unit import hsf_pkg::*; #(
   parameter int GRID_MAX = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW = $clog2(GRID_MAX);
   localparam int GW = $clog2(GRID_MAX + 1);
   localparam int PW = (GW > GRID_REG_W) ? GW : GRID_REG_W;

   logic [COEF_W-1:0]     coef_ff;
   logic [GRID_REG_W-1:0] grid_ff;
   logic [PW-1:0]         grid_ext;
   logic [PW-1:0]         grid_clamp;
   logic [CW-1:0]         g_last;

   logic [CW-1:0]       row_ff;
   logic [CW-1:0]       col_ff;
   logic [CW-1:0]       row_in;
   logic [CW-1:0]       col_in;
   logic [CW-1:0]       row_cur;
   logic [CW-1:0]       col_cur;
   logic                restart;
   logic                row_last;
   logic                col_last;
   logic [SAMPLE_W-1:0] prev_ff;

   logic                advance;
   logic                accept;
   line_pair_type       held [GRID_MAX];
   line_pair_type       entry_pair;
   logic [SAMPLE_W-1:0] centre;
   logic [SAMPLE_W-1:0] east;
   logic [SAMPLE_W-1:0] north;
   logic [LAP_W-2:0]    nbr_sum;

   stage_type     s1_in;
   stage_type     s1_ff;
   logic          s1_valid_ff;
   logic          push_valid;
   oq_entry_type  push_entry;
   oq_status_type oq_status;
   logic          oq_space;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
         grid_ff <= GRID_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STEP_COEF:   coef_ff <= csr_data[COEF_W-1:0];
            CSR_GRID_POINTS: grid_ff <= csr_data[GRID_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign grid_ext = PW'(grid_ff);

   always_comb begin
      if (grid_ext < PW'(GRID_MIN)) begin
         grid_clamp = PW'(GRID_MIN);
      end else if (grid_ext > PW'(GRID_MAX)) begin
         grid_clamp = PW'(GRID_MAX);
      end else begin
         grid_clamp = grid_ext;
      end
   end

   assign g_last = CW'(grid_clamp - PW'(1));

   // Handshake
   assign advance   = oq_space;
   assign req_ready = advance;
   assign accept    = req_valid & advance;

   // Position in the grid
   assign restart  = req_data.frame_start | (row_ff > g_last) | (col_ff > g_last);
   assign row_cur  = restart ? '0 : row_ff;
   assign col_cur  = restart ? '0 : col_ff;
   assign row_last = (row_cur == g_last);
   assign col_last = (col_cur == g_last);

   always_comb begin
      col_in = col_cur + 1'b1;
      row_in = row_cur;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_cur + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         prev_ff <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         prev_ff <= centre;
      end
   end

   // Line buffer cells: slot 0 is the current column of the rows above,
   // slot 1 the next column. New pairs enter at slot grid size minus one.
   assign entry_pair.newer = req_data.sample;
   assign entry_pair.older = held[0].newer;

   for (genvar j = 0; j < GRID_MAX; j++) begin : g_cell
      if (j == GRID_MAX - 1) begin : g_top
         hsf_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .is_entry (g_last == CW'(j)),
            .entry    (entry_pair),
            .next     ('0),
            .held     (held[j])
         );
      end else begin : g_mid
         hsf_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .is_entry (g_last == CW'(j)),
            .entry    (entry_pair),
            .next     (held[j+1]),
            .held     (held[j])
         );
      end
   end

   assign centre = held[0].newer;
   assign east   = held[1].newer;
   assign north  = held[0].older;

   // Front stage: laplacian and border flags
   assign nbr_sum = (LAP_W-1)'(north) + (LAP_W-1)'(req_data.sample)
                  + (LAP_W-1)'(east) + (LAP_W-1)'(prev_ff);

   assign s1_in.lap    = $signed({1'b0, nbr_sum}) - $signed({1'b0, centre, 2'b00});
   assign s1_in.centre = centre;
   assign s1_in.emit   = (row_cur != '0);
   assign s1_in.dual   = row_last;
   assign s1_in.border = (row_cur == CW'(1)) | (col_cur == '0) | col_last;
   assign s1_in.last   = col_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

   hsf_update u_update (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .coef        (coef_ff),
      .stage_valid (s1_valid_ff),
      .stage       (s1_ff),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   hsf_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .space      (oq_space),
      .status     (oq_status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      oq_status.count <= OQ_CNT_W'(OQ_DEPTH))
      else $error("result queue count beyond depth");

   a_last_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_last |-> oq_status.phase)
      else $error("is_last outside the second result of a step");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.frame_start |=> (row_ff == '0) && (col_ff == CW'(1)))
      else $error("frame start did not restart the position");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> oq_status.count != OQ_CNT_W'(OQ_DEPTH))
      else $error("push into a full result queue");

endmodule

[rtl/hsf_cell.sv]
// One column slot of the shifting line buffers: holds the newer-row and
// older-row samples and passes them to its lower neighbor. Uses hsf_pkg.
module hsf_cell import hsf_pkg::*; (
   input  logic          clock,
   input  logic          shift_en,
   input  logic          is_entry,
   input  line_pair_type entry,
   input  line_pair_type next,
   output line_pair_type held
);

   line_pair_type held_ff;
   line_pair_type held_in;

   // The entry slot takes the new pair; all others take their upper neighbor.
   assign held_in = is_entry ? entry : next;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         held_ff <= held_in;
      end
   end

   assign held = held_ff;

endmodule

[rtl/hsf_update.sv]
// Multiply and round/saturate stages of the stencil update.
// Takes the registered laplacian from the front stage; uses hsf_pkg.
module hsf_update import hsf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [COEF_W-1:0] coef,
   input  logic              stage_valid,
   input  stage_type         stage,
   output logic              push_valid,
   output oq_entry_type      push_entry
);

   logic signed [MUL_W-1:0] coef_x;
   logic signed [MUL_W-1:0] lap_x;
   logic signed [MUL_W-1:0] prod_in;
   logic signed [MUL_W-1:0] prod_ff;
   ctl_type                 ctl_in;
   ctl_type                 ctl_ff;
   logic                    valid_ff;

   logic signed [RND_W-1:0]   rnd;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W-1:0]   total;
   logic [SAMPLE_W-1:0]       value;

   assign coef_x  = MUL_W'($signed({1'b0, coef}));
   assign lap_x   = MUL_W'(stage.lap);
   assign prod_in = coef_x * lap_x;

   assign ctl_in.centre = stage.centre;
   assign ctl_in.emit   = stage.emit;
   assign ctl_in.dual   = stage.dual;
   assign ctl_in.border = stage.border;
   assign ctl_in.last   = stage.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         ctl_ff  <= ctl_in;
      end
   end

   // Round half up, then floor by dropping the fraction bits.
   assign rnd   = $signed({prod_ff[MUL_W-1], prod_ff}) + $signed(ROUND_HALF);
   assign delta = rnd[RND_W-1:FRAC_SHIFT];
   assign total = $signed({{(SUM_W-SAMPLE_W){1'b0}}, ctl_ff.centre})
                + $signed({delta[DELTA_W-1], delta});

   always_comb begin
      if (ctl_ff.border || total < 0) begin
         value = '0;
      end else if (total > $signed({{(SUM_W-SAMPLE_W){1'b0}}, ONE_Q15})) begin
         value = ONE_Q15;
      end else begin
         value = total[SAMPLE_W-1:0];
      end
   end

   assign push_valid            = valid_ff & ctl_ff.emit & advance;
   assign push_entry.value      = value;
   assign push_entry.has_second = ctl_ff.dual;
   assign push_entry.last       = ctl_ff.last;

endmodule

[rtl/hsf_outq.sv]
// Result queue: two entries, each giving one result or, in the last row,
// the stencil result followed by the zero border result. Uses hsf_pkg.
module hsf_outq import hsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  oq_entry_type  push_entry,
   output logic          space,
   output oq_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   oq_entry_type        entries_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] wr_ptr_ff;
   logic [OQ_PTR_W-1:0] rd_ptr_ff;
   logic [OQ_CNT_W-1:0] count_ff;
   logic [OQ_CNT_W-1:0] count_in;
   logic                phase_ff;
   logic                phase_in;
   oq_entry_type        head;
   logic                transfer;
   logic                pop;

   assign head      = entries_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign space     = (count_ff != OQ_CNT_W'(OQ_DEPTH));
   assign transfer  = rsp_valid & rsp_ready;
   assign pop       = transfer & (~head.has_second | phase_ff);

   assign rsp_data.value   = phase_ff ? '0 : head.value;
   assign rsp_data.is_last = phase_ff & head.last;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      phase_in = phase_ff;
      if (transfer) begin
         phase_in = head.has_second & ~phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         phase_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign status.count = count_ff;
   assign status.phase = phase_ff;

endmodule
